### rtl/ppvc_pkg.sv
// ----------------------------------------------------------------------------
// ppvc_pkg
// shared types, constants and the cordic angle table for the pure pursuit
// velocity command pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppvc_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LINEAR_GAIN    = 2'd0,
		REG_ANGULAR_GAIN   = 2'd1,
		REG_GOAL_TOLERANCE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic        [15:0] robot_heading;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} item_t;

	typedef struct packed {
		logic signed [31:0] linear_command;
		logic signed [31:0] angular_command;
		logic               goal_reached;
		logic               target_coincident;
		logic               saturated;
	} result_t;

	// data riding along the rotation stages
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] gx;
		logic signed [32:0] gy;
		logic               flip;
	} cordic_side_t;

	// data riding along the root extraction
	typedef struct packed {
		logic        shifted;
		logic [33:0] ay;
		logic        y_neg;
		logic        coincident;
		logic        reached;
	} geo_side_t;

	// data riding along the curvature divider
	typedef struct packed {
		logic signed [31:0] lin;
		logic               lin_sat;
		logic        [33:0] tgt_dist;
		logic               y_neg;
		logic               coincident;
		logic               reached;
	} lin_side_t;

	// data riding along the rate divider
	typedef struct packed {
		logic signed [31:0] lin;
		logic               lin_sat;
		logic               y_neg;
		logic               coincident;
		logic               reached;
	} ang_side_t;

	// atan(2^-i) in units of 2^24 per turn
	function automatic logic [21:0] cordic_atan(input logic [4:0] i);
		logic [21:0] a;
		unique case (i)
			5'd0:  a = 22'd2097152;
			5'd1:  a = 22'd1238021;
			5'd2:  a = 22'd654136;
			5'd3:  a = 22'd332050;
			5'd4:  a = 22'd166669;
			5'd5:  a = 22'd83416;
			5'd6:  a = 22'd41718;
			5'd7:  a = 22'd20860;
			5'd8:  a = 22'd10430;
			5'd9:  a = 22'd5215;
			5'd10: a = 22'd2608;
			5'd11: a = 22'd1304;
			5'd12: a = 22'd652;
			5'd13: a = 22'd326;
			5'd14: a = 22'd163;
			5'd15: a = 22'd81;
			5'd16: a = 22'd41;
			5'd17: a = 22'd20;
			5'd18: a = 22'd10;
			5'd19: a = 22'd5;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

### rtl/ppvc_sqrt.sv
// ----------------------------------------------------------------------------
// ppvc_sqrt
// pipelined integer square root of a 64 bit value, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppvc_sqrt #(
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [63:0]       radicand,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [31:0]            root,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int STEPS = 32;

	logic [63:0]       v_s    [STEPS];
	logic [63:0]       r_s    [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic              vld_s  [STEPS];

	logic [63:0]       v_in   [STEPS];
	logic [63:0]       r_in   [STEPS];
	logic [63:0]       v_nxt  [STEPS];
	logic [63:0]       r_nxt  [STEPS];
	logic [63:0]       trial  [STEPS];

	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			if (k == 0) begin
				v_in[k] = radicand;
				r_in[k] = '0;
			end else begin
				v_in[k] = v_s[k-1];
				r_in[k] = r_s[k-1];
			end
			trial[k] = r_in[k] + (64'd1 << (62 - 2 * k));
			if (v_in[k] >= trial[k]) begin
				v_nxt[k] = v_in[k] - trial[k];
				r_nxt[k] = (r_in[k] >> 1) + (64'd1 << (62 - 2 * k));
			end else begin
				v_nxt[k] = v_in[k];
				r_nxt[k] = r_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < STEPS; k++) vld_s[k] <= (k == 0) ? in_valid : vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STEPS; k++) begin
				v_s[k]    <= v_nxt[k];
				r_s[k]    <= r_nxt[k];
				side_s[k] <= (k == 0) ? side_in : side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign root      = r_s[STEPS-1][31:0];
	assign side_out  = side_s[STEPS-1];

endmodule

`default_nettype wire

### rtl/ppvc_div.sv
// ----------------------------------------------------------------------------
// ppvc_div
// pipelined restoring divider, one quotient bit per stage; the caller
// guarantees num >> Q_W is below den (NUM_W > Q_W, NUM_W - Q_W <= DEN_W)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppvc_div #(
	parameter int NUM_W  = 64,
	parameter int DEN_W  = 34,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quo,
	output logic [SIDE_W-1:0]      side_out
);

	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    nlo_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic              vld_s  [Q_W];

	logic [DEN_W-1:0]  rem_in  [Q_W];
	logic [Q_W-1:0]    nlo_in  [Q_W];
	logic [Q_W-1:0]    quo_in  [Q_W];
	logic [DEN_W-1:0]  den_in  [Q_W];
	logic [DEN_W:0]    trial   [Q_W];
	logic [DEN_W-1:0]  rem_nxt [Q_W];
	logic [Q_W-1:0]    quo_nxt [Q_W];

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				rem_in[k] = DEN_W'(num[NUM_W-1:Q_W]);
				nlo_in[k] = num[Q_W-1:0];
				quo_in[k] = '0;
				den_in[k] = den;
			end else begin
				rem_in[k] = rem_s[k-1];
				nlo_in[k] = nlo_s[k-1];
				quo_in[k] = quo_s[k-1];
				den_in[k] = den_s[k-1];
			end
			trial[k] = {rem_in[k], nlo_in[k][Q_W-1]};
			if (trial[k] >= {1'b0, den_in[k]}) begin
				rem_nxt[k] = DEN_W'(trial[k] - {1'b0, den_in[k]});
				quo_nxt[k] = {quo_in[k][Q_W-2:0], 1'b1};
			end else begin
				rem_nxt[k] = trial[k][DEN_W-1:0];
				quo_nxt[k] = {quo_in[k][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Q_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < Q_W; k++) vld_s[k] <= (k == 0) ? in_valid : vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k]  <= rem_nxt[k];
				nlo_s[k]  <= nlo_in[k] << 1;
				quo_s[k]  <= quo_nxt[k];
				den_s[k]  <= den_in[k];
				side_s[k] <= (k == 0) ? side_in : side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

`default_nettype wire

### rtl/pure_pursuit_velocity_command.sv
// ----------------------------------------------------------------------------
// pure_pursuit_velocity_command
// throughput: one item per cycle while the output is not stalled; the depth
// comes from the 20 rotation stages, the 32 stage root and the 32 and 44
// stage restoring dividers
// reset: arst_n empties the pipeline and loads the gains to 1.0 and the
// goal tolerance to 6554 (about 0.1 m)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pure_pursuit_velocity_command (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input items
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire ppvc_pkg::item_t   item,
	// results
	output logic                   result_valid,
	input  wire logic              result_stall,
	output ppvc_pkg::result_t      result,
	// configuration writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire ppvc_pkg::cfg_reg_t cfg_index,
	input  wire logic [31:0]       cfg_data
);

	import ppvc_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0] linear_gain_q;
	logic [15:0] angular_gain_q;
	logic [30:0] goal_tol_q;
	logic [61:0] tol_sq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_gain_q  <= 16'd256;
			angular_gain_q <= 16'd256;
			goal_tol_q     <= 31'd6554;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINEAR_GAIN:    linear_gain_q  <= cfg_data[15:0];
				REG_ANGULAR_GAIN:   angular_gain_q <= cfg_data[15:0];
				REG_GOAL_TOLERANCE: goal_tol_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// squared tolerance is registered from goal_tol_q; config changes are for the
	// user to make only while the pipeline is empty; not enforced by the block
	always_ff @(posedge clk) begin
		tol_sq_q <= 62'(goal_tol_q) * 62'(goal_tol_q);
	end

	// ------------------------------------------------------------------
	// global pipeline advance: everything moves unless the output register
	// holds a transaction that the consumer is stalling
	// ------------------------------------------------------------------
	logic en;
	logic result_valid_q;
	result_t result_q;

	assign en           = !(result_valid_q && result_stall);
	assign item_stall   = !en;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------
	// s1: offsets and heading fold into [-90, 90] degrees
	// ------------------------------------------------------------------
	logic signed [16:0] hz, hf;
	logic               flip_c;

	always_comb begin
		hz = 17'(signed'(item.robot_heading));
		if (hz > 17'sd16384) begin
			hf     = hz - 17'sd32768;
			flip_c = 1'b1;
		end else if (hz < -17'sd16384) begin
			hf     = hz + 17'sd32768;
			flip_c = 1'b1;
		end else begin
			hf     = hz;
			flip_c = 1'b0;
		end
	end

	logic               vld_s1;
	logic signed [24:0] z0_s1;
	cordic_side_t       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z0_s1        <= $signed({hf, 8'b0});
			side_s1.dx   <= 33'(item.target_x) - 33'(item.robot_x);
			side_s1.dy   <= 33'(item.target_y) - 33'(item.robot_y);
			side_s1.gx   <= 33'(item.goal_x) - 33'(item.robot_x);
			side_s1.gy   <= 33'(item.goal_y) - 33'(item.robot_y);
			side_s1.flip <= flip_c;
		end
	end

	// ------------------------------------------------------------------
	// cordic rotation, one micro-rotation per stage
	// ------------------------------------------------------------------
	logic signed [31:0] cx_s   [CORDIC_STEPS];
	logic signed [31:0] cy_s   [CORDIC_STEPS];
	logic signed [24:0] cz_s   [CORDIC_STEPS];
	cordic_side_t       cside_s[CORDIC_STEPS];
	logic               cvld_s [CORDIC_STEPS];

	logic signed [31:0] cx_in  [CORDIC_STEPS];
	logic signed [31:0] cy_in  [CORDIC_STEPS];
	logic signed [24:0] cz_in  [CORDIC_STEPS];
	logic signed [31:0] cx_nxt [CORDIC_STEPS];
	logic signed [31:0] cy_nxt [CORDIC_STEPS];
	logic signed [24:0] cz_nxt [CORDIC_STEPS];
	logic signed [24:0] c_ang  [CORDIC_STEPS];

	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (i == 0) begin
				cx_in[i] = CORDIC_GAIN;
				cy_in[i] = '0;
				cz_in[i] = z0_s1;
			end else begin
				cx_in[i] = cx_s[i-1];
				cy_in[i] = cy_s[i-1];
				cz_in[i] = cz_s[i-1];
			end
			c_ang[i] = $signed({3'b000, cordic_atan(5'(i))});
			// rotate toward zero residual angle, floor shifts
			if (!cz_in[i][24]) begin
				cx_nxt[i] = cx_in[i] - (cy_in[i] >>> i);
				cy_nxt[i] = cy_in[i] + (cx_in[i] >>> i);
				cz_nxt[i] = cz_in[i] - c_ang[i];
			end else begin
				cx_nxt[i] = cx_in[i] + (cy_in[i] >>> i);
				cy_nxt[i] = cy_in[i] - (cx_in[i] >>> i);
				cz_nxt[i] = cz_in[i] + c_ang[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_STEPS; i++) cvld_s[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++)
				cvld_s[i] <= (i == 0) ? vld_s1 : cvld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				cx_s[i]    <= cx_nxt[i];
				cy_s[i]    <= cy_nxt[i];
				cz_s[i]    <= cz_nxt[i];
				cside_s[i] <= (i == 0) ? side_s1 : cside_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s22: undo the half-turn fold, goal offset magnitudes
	// ------------------------------------------------------------------
	cordic_side_t       cs_last;
	logic               vld_s22;
	logic signed [31:0] cos_s22, sin_s22;
	logic signed [32:0] dx_s22, dy_s22;
	logic        [32:0] gax_s22, gay_s22;

	assign cs_last = cside_s[CORDIC_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s22 <= 1'b0;
		else if (en) vld_s22 <= cvld_s[CORDIC_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s22 <= cs_last.flip ? -cx_s[CORDIC_STEPS-1] : cx_s[CORDIC_STEPS-1];
			sin_s22 <= cs_last.flip ? -cy_s[CORDIC_STEPS-1] : cy_s[CORDIC_STEPS-1];
			dx_s22  <= cs_last.dx;
			dy_s22  <= cs_last.dy;
			gax_s22 <= cs_last.gx[32] ? 33'(-cs_last.gx) : 33'(cs_last.gx);
			gay_s22 <= cs_last.gy[32] ? 33'(-cs_last.gy) : 33'(cs_last.gy);
		end
	end

	// ------------------------------------------------------------------
	// s23: rotation products and goal squares
	// ------------------------------------------------------------------
	logic               vld_s23;
	logic signed [64:0] pxc_s23, pys_s23, pyc_s23, pxs_s23;
	logic        [65:0] gsx_s23, gsy_s23;
	logic               glt_s23;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s23 <= 1'b0;
		else if (en) vld_s23 <= vld_s22;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s23 <= 65'(dx_s22) * 65'(cos_s22);
			pys_s23 <= 65'(dy_s22) * 65'(sin_s22);
			pyc_s23 <= 65'(dy_s22) * 65'(cos_s22);
			pxs_s23 <= 65'(dx_s22) * 65'(sin_s22);
			gsx_s23 <= 66'(gax_s22) * 66'(gax_s22);
			gsy_s23 <= 66'(gay_s22) * 66'(gay_s22);
			glt_s23 <= (gax_s22 < 33'(goal_tol_q)) && (gay_s22 < 33'(goal_tol_q));
		end
	end

	// ------------------------------------------------------------------
	// s24: rounded local coordinates, goal distance compare
	// ------------------------------------------------------------------
	localparam logic signed [65:0] ROUND_HALF = 66'sd134217728;

	logic signed [65:0] xsum, ysum;
	logic               vld_s24;
	logic signed [35:0] xl_s24, yl_s24;
	logic               reached_s24;

	assign xsum = 66'(pxc_s23) + 66'(pys_s23) + ROUND_HALF;
	assign ysum = 66'(pyc_s23) - 66'(pxs_s23) + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s24 <= 1'b0;
		else if (en) vld_s24 <= vld_s23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xl_s24      <= xsum[63:28];
			yl_s24      <= ysum[63:28];
			reached_s24 <= glt_s23 && ((67'(gsx_s23) + 67'(gsy_s23)) < 67'(tol_sq_q));
		end
	end

	// ------------------------------------------------------------------
	// s25: magnitudes, far-target prescale
	// ------------------------------------------------------------------
	logic [35:0] axw, ayw;
	logic        far;

	assign axw = xl_s24[35] ? 36'(-xl_s24) : 36'(xl_s24);
	assign ayw = yl_s24[35] ? 36'(-yl_s24) : 36'(yl_s24);
	assign far = (|axw[34:31]) || (|ayw[34:31]);

	logic        vld_s25;
	logic [31:0] axs_s25, ays_s25;
	geo_side_t   geo_s25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s25 <= 1'b0;
		else if (en) vld_s25 <= vld_s24;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axs_s25            <= far ? axw[33:2] : axw[31:0];
			ays_s25            <= far ? ayw[33:2] : ayw[31:0];
			geo_s25.shifted    <= far;
			geo_s25.ay         <= ayw[33:0];
			geo_s25.y_neg      <= yl_s24[35];
			geo_s25.coincident <= (xl_s24 == '0) && (yl_s24 == '0);
			geo_s25.reached    <= reached_s24;
		end
	end

	// ------------------------------------------------------------------
	// s26, s27: squared local distance
	// ------------------------------------------------------------------
	logic        vld_s26, vld_s27;
	logic [63:0] sqx_s26, sqy_s26, dsq_s27;
	geo_side_t   geo_s26, geo_s27;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s26 <= 1'b0;
			vld_s27 <= 1'b0;
		end else if (en) begin
			vld_s26 <= vld_s25;
			vld_s27 <= vld_s26;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s26 <= 64'(axs_s25) * 64'(axs_s25);
			sqy_s26 <= 64'(ays_s25) * 64'(ays_s25);
			geo_s26 <= geo_s25;
			dsq_s27 <= sqx_s26 + sqy_s26;
			geo_s27 <= geo_s26;
		end
	end

	// ------------------------------------------------------------------
	// root extraction, 32 stages
	// ------------------------------------------------------------------
	logic        sq_vld;
	logic [31:0] sq_root;
	logic [$bits(geo_side_t)-1:0] sq_side_bits;
	geo_side_t   sq_side;

	ppvc_sqrt #(
		.SIDE_W($bits(geo_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s27),
		.radicand  (dsq_s27),
		.side_in   (geo_s27),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sq_side_bits)
	);

	assign sq_side = geo_side_t'(sq_side_bits);

	// ------------------------------------------------------------------
	// s60: undo prescale; s61: linear speed product
	// ------------------------------------------------------------------
	logic        vld_s60, vld_s61;
	logic [33:0] d_s60, d_s61;
	geo_side_t   geo_s60, geo_s61;
	logic [49:0] lmag_s61;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s60 <= 1'b0;
			vld_s61 <= 1'b0;
		end else if (en) begin
			vld_s60 <= sq_vld;
			vld_s61 <= vld_s60;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s60    <= sq_side.shifted ? {sq_root, 2'b00} : {2'b00, sq_root};
			geo_s60  <= sq_side;
			d_s61    <= d_s60;
			geo_s61  <= geo_s60;
			lmag_s61 <= 50'(linear_gain_q) * 50'(d_s60);
		end
	end

	// linear clip; goal reached forces zero and hides the clip
	logic [41:0] lshift;
	lin_side_t   lin_side;

	assign lshift = lmag_s61[49:8];

	always_comb begin
		lin_side.tgt_dist   = d_s61;
		lin_side.y_neg      = geo_s61.y_neg;
		lin_side.coincident = geo_s61.coincident;
		lin_side.reached    = geo_s61.reached;
		if (geo_s61.reached) begin
			lin_side.lin     = '0;
			lin_side.lin_sat = 1'b0;
		end else if (lshift > 42'h0007FFFFFFF) begin
			lin_side.lin     = 32'sh7FFFFFFF;
			lin_side.lin_sat = 1'b1;
		end else begin
			lin_side.lin     = $signed(lshift[31:0]);
			lin_side.lin_sat = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// curvature divider: |y_local| * 2^30 / d, 32 quotient bits
	// ------------------------------------------------------------------
	logic        dv1_vld;
	logic [31:0] dv1_quo;
	logic [$bits(lin_side_t)-1:0] dv1_side_bits;
	lin_side_t   dv1_side;

	ppvc_div #(
		.NUM_W  (64),
		.DEN_W  (34),
		.Q_W    (32),
		.SIDE_W ($bits(lin_side_t))
	) u_div_curv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s61),
		.num       ({geo_s61.ay, 30'b0}),
		.den       (d_s61),
		.side_in   (lin_side),
		.out_valid (dv1_vld),
		.quo       (dv1_quo),
		.side_out  (dv1_side_bits)
	);

	assign dv1_side = lin_side_t'(dv1_side_bits);

	// ------------------------------------------------------------------
	// s94: gain product and scaled denominator
	// ------------------------------------------------------------------
	logic        vld_s94;
	logic [47:0] aprod_s94;
	logic [38:0] aden_s94;
	ang_side_t   ang_s94;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s94 <= 1'b0;
		else if (en) vld_s94 <= dv1_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aprod_s94          <= 48'(angular_gain_q) * 48'(dv1_quo);
			aden_s94           <= {dv1_side.tgt_dist, 5'b0};
			ang_s94.lin        <= dv1_side.lin;
			ang_s94.lin_sat    <= dv1_side.lin_sat;
			ang_s94.y_neg      <= dv1_side.y_neg;
			ang_s94.coincident <= dv1_side.coincident;
			ang_s94.reached    <= dv1_side.reached;
		end
	end

	// ------------------------------------------------------------------
	// rate divider: gain * s / (32 d), 44 quotient bits
	// ------------------------------------------------------------------
	logic        dv2_vld;
	logic [43:0] dv2_quo;
	logic [$bits(ang_side_t)-1:0] dv2_side_bits;
	ang_side_t   dv2_side;

	ppvc_div #(
		.NUM_W  (48),
		.DEN_W  (39),
		.Q_W    (44),
		.SIDE_W ($bits(ang_side_t))
	) u_div_rate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s94),
		.num       (aprod_s94),
		.den       (aden_s94),
		.side_in   (ang_s94),
		.out_valid (dv2_vld),
		.quo       (dv2_quo),
		.side_out  (dv2_side_bits)
	);

	assign dv2_side = ang_side_t'(dv2_side_bits);

	// ------------------------------------------------------------------
	// angular sign and clip, output register
	// ------------------------------------------------------------------
	logic signed [31:0] ang_c;
	logic               ang_sat;

	always_comb begin
		if (dv2_side.coincident) begin
			// coincident target: no rate command
			ang_c   = '0;
			ang_sat = 1'b0;
		end else if (!dv2_side.y_neg) begin
			if (dv2_quo > 44'h0007FFFFFFF) begin
				ang_c   = 32'sh7FFFFFFF;
				ang_sat = 1'b1;
			end else begin
				ang_c   = $signed(dv2_quo[31:0]);
				ang_sat = 1'b0;
			end
		end else begin
			if (dv2_quo > 44'h00080000000) begin
				ang_c   = $signed(32'h80000000);
				ang_sat = 1'b1;
			end else begin
				ang_c   = $signed(-dv2_quo[31:0]);
				ang_sat = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (en) result_valid_q <= dv2_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.linear_command    <= dv2_side.lin;
			result_q.angular_command   <= ang_c;
			result_q.goal_reached      <= dv2_side.reached;
			result_q.target_coincident <= dv2_side.coincident;
			result_q.saturated         <= dv2_side.lin_sat || ang_sat;
		end
	end

endmodule

`default_nettype wire

### rtl/ppvc_checker.sv
// ----------------------------------------------------------------------------
// ppvc_checker
// port-level assertions for the pure pursuit velocity command block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppvc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire ppvc_pkg::result_t result
);

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	// a stalled transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// input only backs up when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without output back-pressure");

	// goal reached zeroes linear speed
	a_goal_stop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.goal_reached |-> result.linear_command == '0)
		else $error("linear command nonzero at goal");

	// coincident target zeroes the rate
	a_coincident: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.target_coincident |-> result.angular_command == '0)
		else $error("angular command nonzero for coincident target");

endmodule

bind pure_pursuit_velocity_command ppvc_checker u_ppvc_checker (.*);

`default_nettype wire

### tb/pure_pursuit_velocity_command_tb.sv
// ----------------------------------------------------------------------------
// pure_pursuit_velocity_command_tb
// drives pose/target/goal items through the velocity command block and checks
// every result against a typed expectation or a bit exact fixed point
// predictor, over several gain and tolerance settings, with random idling on
// both sides
`timescale 1ns / 1ps
`default_nettype none

module pure_pursuit_velocity_command_tb;
	import ppvc_pkg::*;

	localparam int N_RANDOM    = 1050;
	localparam int N_PHASES    = 5;
	localparam int DRAIN_WAIT  = 200;	// longer than an item's trip through the pipeline

	// directed stimulus row: typed expectation only where obvious
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the configuration
	logic [15:0] lin_gain_q;
	logic [15:0] ang_gain_q;
	logic [30:0] goal_tol_q;

	result_t cmd_pending_q[$];	// predicted for the item on the bus
	result_t cmd_expect_q[$];	// predicted for accepted transactions
	int      n_item_acc;
	int      n_cfg_acc;
	int      n_errors;
	bit      calm;			// no idling on either side

	pure_pursuit_velocity_command u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// a generous cap, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// fixed point model of one control tick
	function automatic result_t steer_predict(item_t it);
		longint rx, ry, dx, dy, gx, gy;
		longint cx, cy, nx, z, c, s, xl, yl;
		longint unsigned ax, ay, sx, sy, v, r, b, d;
		longint unsigned lmag, sr, amag, gax, gay, tol;
		longint atan_tab[20];
		bit flip, coin, reach, sat;
		result_t o;
		atan_tab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
			20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
		rx = longint'(it.robot_x);
		ry = longint'(it.robot_y);
		dx = longint'(it.target_x) - rx;
		dy = longint'(it.target_y) - ry;
		gx = longint'(it.goal_x) - rx;
		gy = longint'(it.goal_y) - ry;

		// fold heading into +-90 degrees, then rotate the gain vector
		z = longint'(it.robot_heading);
		flip = 1'b0;
		if (z >= 32768) z = z - 65536;
		if (z > 16384) begin
			z = z - 32768;
			flip = 1'b1;
		end else if (z < -16384) begin
			z = z + 32768;
			flip = 1'b1;
		end
		z = z * 256;
		cx = 163008219;
		cy = 0;
		for (int i = 0; i < 20; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z = z - atan_tab[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z = z + atan_tab[i];
			end
			cx = nx;
		end
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;

		// target offset in the robot frame
		xl = (dx * c + dy * s + (64'sd1 <<< 27)) >>> 28;
		yl = (dy * c - dx * s + (64'sd1 <<< 27)) >>> 28;
		ax = (xl < 0) ? longint'(-xl) : xl;
		ay = (yl < 0) ? longint'(-yl) : yl;

		// far target: root of the coordinates scaled down by 4
		if (ax >= 64'd2147483648 || ay >= 64'd2147483648) begin
			sx = ax >> 2;
			sy = ay >> 2;
		end else begin
			sx = ax;
			sy = ay;
		end
		v = sx * sx + sy * sy;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		d = (sx != ax || sy != ay) ? (r << 2) : r;
		coin = (xl == 0 && yl == 0);

		// goal test on exact squared distances
		gax = (gx < 0) ? longint'(-gx) : gx;
		gay = (gy < 0) ? longint'(-gy) : gy;
		tol = goal_tol_q;
		reach = gax < tol && gay < tol && gax * gax + gay * gay < tol * tol;

		sat = 1'b0;
		lmag = (longint'(lin_gain_q) * d) >> 8;
		if (reach) begin
			o.linear_command = '0;
		end else if (lmag > 64'h7FFF_FFFF) begin
			o.linear_command = 32'h7FFF_FFFF;
			sat = 1'b1;
		end else begin
			o.linear_command = lmag[31:0];
		end

		o.angular_command = '0;
		if (!coin && d != 0) begin
			sr = (ay << 30) / d;
			amag = (longint'(ang_gain_q) * sr) / (d * 32);
			if (yl >= 0) begin
				if (amag > 64'h7FFF_FFFF) begin
					amag = 64'h7FFF_FFFF;
					sat = 1'b1;
				end
				o.angular_command = amag[31:0];
			end else begin
				if (amag > 64'h8000_0000) begin
					amag = 64'h8000_0000;
					sat = 1'b1;
				end
				o.angular_command = -amag[31:0];
			end
		end
		o.goal_reached = reach;
		o.target_coincident = coin;
		o.saturated = sat;
		return o;
	endfunction

	// monitor: bookkeeping for input transactions and result checks
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				cmd_expect_q.insert(cmd_expect_q.size(), cmd_pending_q.pop_front());
				n_item_acc <= n_item_acc + 1;
			end
			if (cfg_valid && cfg_ready)
				n_cfg_acc <= n_cfg_acc + 1;
			if (result_valid && !result_stall) begin
				if (cmd_expect_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result %h", $time, result);
				end else begin
					want = cmd_expect_q.pop_front();
					if (result.linear_command !== want.linear_command) begin
						n_errors++;
						$display("%0t: linear_command exp %0d got %0d", $time,
							want.linear_command, result.linear_command);
					end
					if (result.angular_command !== want.angular_command) begin
						n_errors++;
						$display("%0t: angular_command exp %0d got %0d", $time,
							want.angular_command, result.angular_command);
					end
					if (result.goal_reached !== want.goal_reached) begin
						n_errors++;
						$display("%0t: goal_reached exp %b got %b", $time,
							want.goal_reached, result.goal_reached);
					end
					if (result.target_coincident !== want.target_coincident) begin
						n_errors++;
						$display("%0t: target_coincident exp %b got %b", $time,
							want.target_coincident, result.target_coincident);
					end
					if (result.saturated !== want.saturated) begin
						n_errors++;
						$display("%0t: saturated exp %b got %b", $time,
							want.saturated, result.saturated);
					end
				end
			end
		end
	end

	// receiver back-pressure in random bursts
	always @(negedge clk) begin
		int hold;
		if (calm || !arst_n) begin
			result_stall <= 1'b0;
			hold = 0;
		end else if (hold > 0) begin
			result_stall <= 1'b1;
			hold--;
		end else if ($urandom_range(0, 6) == 0) begin
			result_stall <= 1'b1;
			hold = $urandom_range(0, 4);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// one input transaction; entered and left on a falling edge
	task automatic send_item(item_t it, result_t want);
		int seen;
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd_pending_q.insert(cmd_pending_q.size(), want);
		item <= it;
		item_valid <= 1'b1;
		seen = n_item_acc;
		do @(negedge clk); while (n_item_acc == seen);
	endtask

	// hold the sender until every result is back
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (cmd_expect_q.size() != 0 || cmd_pending_q.size() != 0)
			@(negedge clk);
	endtask

	// register write while the pipeline is empty
	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		int seen;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		seen = n_cfg_acc;
		do @(negedge clk); while (n_cfg_acc == seen);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LINEAR_GAIN:    lin_gain_q = val[15:0];
			REG_ANGULAR_GAIN:   ang_gain_q = val[15:0];
			REG_GOAL_TOLERANCE: goal_tol_q = val[30:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// signed offset of up to nbits magnitude
	function automatic logic [31:0] rand_offset(int nbits);
		logic [31:0] m;
		m = $urandom() & ((nbits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 1));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int mode;
		it.robot_x = $urandom();
		it.robot_y = $urandom();
		it.robot_heading = $urandom();
		mode = $urandom_range(0, 9);
		case (mode)
			5: begin
				it.target_x = $urandom();
				it.target_y = $urandom();
				it.goal_x = $urandom();
				it.goal_y = $urandom();
			end
			6: begin	// target on the robot
				it.target_x = it.robot_x;
				it.target_y = it.robot_y;
				it.goal_x = it.robot_x + rand_offset(20);
				it.goal_y = it.robot_y + rand_offset(20);
			end
			7: begin	// goal near the robot
				it.target_x = it.robot_x + rand_offset(18);
				it.target_y = it.robot_y + rand_offset(18);
				it.goal_x = it.robot_x + rand_offset(13);
				it.goal_y = it.robot_y + rand_offset(13);
			end
			8: begin	// tiny offsets, steep curvature
				it.target_x = it.robot_x + rand_offset(4);
				it.target_y = it.robot_y + rand_offset(4);
				it.goal_x = it.robot_x + rand_offset(24);
				it.goal_y = it.robot_y + rand_offset(24);
			end
			9: begin	// far target
				it.target_x = it.robot_x + rand_offset(31);
				it.target_y = it.robot_y + rand_offset(31);
				it.goal_x = it.robot_x + rand_offset(31);
				it.goal_y = it.robot_y + rand_offset(31);
			end
			default: begin
				it.target_x = it.robot_x + rand_offset($urandom_range(8, 22));
				it.target_y = it.robot_y + rand_offset($urandom_range(8, 22));
				it.goal_x = it.robot_x + rand_offset($urandom_range(8, 24));
				it.goal_y = it.robot_y + rand_offset($urandom_range(8, 24));
			end
		endcase
		return it;
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		item_t it;
		int per_phase;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LINEAR_GAIN;
		cfg_data = '0;
		n_item_acc = 0;
		n_cfg_acc = 0;
		n_errors = 0;
		calm = 1'b0;
		lin_gain_q = 16'd256;
		ang_gain_q = 16'd256;
		goal_tol_q = 31'd6554;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at reset settings
		row.typed = 1'b1;
		row.it = '0;	// everything at the origin: coincident and at goal
		row.want = '{linear_command: 0, angular_command: 0, goal_reached: 1'b1,
			target_coincident: 1'b1, saturated: 1'b0};
		rows.insert(rows.size(), row);
		row.it = '{robot_x: 32'sh7FFF_FFFF, robot_y: 32'sh8000_0000,
			robot_heading: 16'hFFFF, target_x: 32'sh7FFF_FFFF,
			target_y: 32'sh8000_0000, goal_x: 32'sh0, goal_y: 32'sh0};
		row.want = '{linear_command: 0, angular_command: 0, goal_reached: 1'b0,
			target_coincident: 1'b1, saturated: 1'b0};
		rows.insert(rows.size(), row);
		row.typed = 1'b0;
		for (int h = 0; h < 9; h++) begin	// headings across all fold regions
			row.it = '{robot_x: 32'sh0001_0000, robot_y: -32'sh0002_0000,
				robot_heading: 16'(h * 8192 + ((h == 8) ? -1 : 0) + ((h == 2) ? 1 : 0)),
				target_x: 32'sh0004_0000, target_y: 32'sh0001_8000,
				goal_x: 32'sh0010_0000, goal_y: 32'sh0};
			rows.insert(rows.size(), row);
		end
		// far target in both axes, extreme corners
		row.it = '{robot_x: 32'sh8000_0000, robot_y: 32'sh8000_0000,
			robot_heading: 16'h0000, target_x: 32'sh7FFF_FFFF,
			target_y: 32'sh7FFF_FFFF, goal_x: 32'sh7FFF_FFFF, goal_y: 32'sh8000_0000};
		rows.insert(rows.size(), row);
		row.it.robot_heading = 16'h2000;
		rows.insert(rows.size(), row);
		row.it = '{robot_x: 32'sh7FFF_FFFF, robot_y: 32'sh7FFF_FFFF,
			robot_heading: 16'hA000, target_x: 32'sh8000_0000,
			target_y: 32'sh8000_0001, goal_x: 32'sh8000_0000, goal_y: 32'sh7FFF_FFFF};
		rows.insert(rows.size(), row);
		// one unit offsets: steepest curvature
		row.it = '{robot_x: 32'sh0, robot_y: 32'sh0, robot_heading: 16'h0,
			target_x: 32'sh0, target_y: 32'sh1, goal_x: 32'sh0010_0000, goal_y: 32'sh0};
		rows.insert(rows.size(), row);
		row.it.target_y = -32'sh1;
		rows.insert(rows.size(), row);
		// goal just inside and just outside the tolerance
		row.it = '{robot_x: 32'sh0, robot_y: 32'sh0, robot_heading: 16'h4000,
			target_x: 32'sh0003_0000, target_y: 32'sh0, goal_x: 32'sh0000_1999,
			goal_y: 32'sh0};
		rows.insert(rows.size(), row);
		row.it.goal_x = 32'sh0000_199A;
		rows.insert(rows.size(), row);
		row.it.goal_x = 32'sh0000_1200;
		row.it.goal_y = 32'sh0000_1200;
		rows.insert(rows.size(), row);

		foreach (rows[k]) begin
			send_item(rows[k].it, rows[k].typed ? rows[k].want : steer_predict(rows[k].it));
		end

		// random phases, each after a configuration change
		per_phase = N_RANDOM / N_PHASES;
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			repeat (DRAIN_WAIT) @(negedge clk);
			case (p)
				0: begin
					write_reg(REG_LINEAR_GAIN, 32'h0000_FFFF);
					write_reg(REG_ANGULAR_GAIN, 32'h0000_FFFF);
					write_reg(REG_GOAL_TOLERANCE, 32'h7FFF_FFFF);
				end
				1: begin	// zero tolerance never reaches the goal
					write_reg(REG_LINEAR_GAIN, 32'h0);
					write_reg(REG_ANGULAR_GAIN, 32'h0);
					write_reg(REG_GOAL_TOLERANCE, 32'h0);
				end
				2: begin
					write_reg(REG_LINEAR_GAIN, 32'h1);
					write_reg(REG_ANGULAR_GAIN, 32'hFFFF_FFFF);
					write_reg(REG_GOAL_TOLERANCE, 32'h1);
				end
				default: begin
					write_reg(REG_LINEAR_GAIN, $urandom());
					write_reg(REG_ANGULAR_GAIN, $urandom());
					write_reg(REG_GOAL_TOLERANCE, $urandom_range(0, 32'h0004_0000));
				end
			endcase
			calm = (p == N_PHASES - 1);
			for (int n = 0; n < per_phase; n++) begin
				it = rand_item();
				send_item(it, steer_predict(it));
				if (p == 3 && n == per_phase / 2)
					wait_drained();	// sender holds off until everything is back
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0 && cmd_expect_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
